/* hw/rtl/tts_pkg.sv */
// Shared constants, types, microcode table and divisor table of the Taylor series evaluator.
package tts_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int X_W        = 20;
  localparam int SUM_W      = 32;
  localparam int FSEL_W     = 2;
  localparam int TCNT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int QF         = 16;

  localparam int K_W    = $clog2(MAX_TERMS + 1);
  localparam int DIV_W  = $clog2(4 * MAX_TERMS * MAX_TERMS);
  localparam int DIVT_W = DIV_W + 2;
  localparam int AX_W   = X_W;
  localparam int X2_W   = 2 * (X_W - 1) - QF + 1;
  localparam int MAG_W  = SUM_W;
  localparam int PROD_W = MAG_W + X2_W;
  // A clipped magnitude of at most 2^31 times x squared of at most 2^22 stays below 2^38.
  localparam int NUM_W  = (MAG_W - 1) + (X2_W - 1) - QF + 1;
  localparam int DIV_ITER = NUM_W / 2;
  localparam int DCNT_W   = $clog2(DIV_ITER);

  localparam logic [FSEL_W-1:0] FN_EXP  = 2'd0;
  localparam logic [FSEL_W-1:0] FN_SIN  = 2'd1;
  localparam logic [FSEL_W-1:0] FN_COS  = 2'd2;
  localparam logic [FSEL_W-1:0] FN_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FSEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TCNT = 1'b1;

  localparam logic [FSEL_W-1:0] FSEL_RST = FN_EXP;
  localparam logic [TCNT_W-1:0] TCNT_RST = 5'd8;

  localparam logic [MAG_W-1:0]  Q_ONE     = MAG_W'(64'h0001_0000);
  localparam logic [SUM_W-1:0]  Q_NEG_ONE = SUM_W'(-65536);
  localparam logic [NUM_W-1:0]  POS_LIMIT = NUM_W'(64'h7FFF_FFFF);
  localparam logic [NUM_W-1:0]  NEG_LIMIT = NUM_W'(64'h8000_0000);
  localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (QF - 1);

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MUL_SQ,
    OP_X2,
    OP_ACCUM,
    OP_MUL_TERM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_NEXT,
    OP_OUT_SUM,
    OP_OUT_NONE
  } uop_t;

  typedef enum logic [2:0] {
    CD_NEVER,
    CD_ALWAYS,
    CD_NO_START,
    CD_FN_NONE,
    CD_N_ZERO,
    CD_K_LAST,
    CD_DIV_MORE
  } cond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_SQR    = 4'd1;
  localparam logic [PC_W-1:0] ST_X2     = 4'd2;
  localparam logic [PC_W-1:0] ST_TERM   = 4'd3;
  localparam logic [PC_W-1:0] ST_MUL    = 4'd4;
  localparam logic [PC_W-1:0] ST_PREP   = 4'd5;
  localparam logic [PC_W-1:0] ST_DIV    = 4'd6;
  localparam logic [PC_W-1:0] ST_NEXT   = 4'd7;
  localparam logic [PC_W-1:0] ST_FINISH = 4'd8;
  localparam logic [PC_W-1:0] ST_NONE   = 4'd9;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    uop_t op;
    logic accept;
  } ctrl_t;

  typedef struct packed {
    logic fn_none;
    logic n_zero;
    logic k_last;
    logic div_more;
  } stat_t;

  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      ST_IDLE:   w = '{OP_LOAD,     CD_NO_START, ST_IDLE};
      ST_SQR:    w = '{OP_MUL_SQ,   CD_FN_NONE,  ST_NONE};
      ST_X2:     w = '{OP_X2,       CD_N_ZERO,   ST_FINISH};
      ST_TERM:   w = '{OP_ACCUM,    CD_K_LAST,   ST_FINISH};
      ST_MUL:    w = '{OP_MUL_TERM, CD_NEVER,    ST_IDLE};
      ST_PREP:   w = '{OP_DIV_LOAD, CD_NEVER,    ST_IDLE};
      ST_DIV:    w = '{OP_DIV_STEP, CD_DIV_MORE, ST_DIV};
      ST_NEXT:   w = '{OP_NEXT,     CD_ALWAYS,   ST_TERM};
      ST_FINISH: w = '{OP_OUT_SUM,  CD_ALWAYS,   ST_IDLE};
      ST_NONE:   w = '{OP_OUT_NONE, CD_ALWAYS,   ST_IDLE};
      default:   w = '{OP_LOAD,     CD_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [DIV_W-1:0] divisor(logic [FSEL_W-1:0] fsel, logic [K_W-1:0] k);
    logic [DIV_W-1:0] kk;
    logic [DIV_W-1:0] d;
    kk = DIV_W'(k) << 1;
    unique case (fsel)
      FN_SIN:  d = kk * (kk + DIV_W'(1));
      FN_COS:  d = (kk - DIV_W'(1)) * kk;
      default: d = DIV_W'(k);
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/tts_useq.sv */
// Microcode sequencer: step counter, control store and jump conditions.
module tts_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tts_pkg::stat_t stat,
  output tts_pkg::ctrl_t ctrl,
  output logic          busy
);

  logic [tts_pkg::PC_W-1:0] pc_r;
  logic [tts_pkg::PC_W-1:0] pc_nxt;
  tts_pkg::ucw_t            ucw;
  logic                     jump;

  assign ucw = tts_pkg::ucode(pc_r);

  always_comb begin
    unique case (ucw.cond)
      tts_pkg::CD_NEVER:    jump = 1'b0;
      tts_pkg::CD_ALWAYS:   jump = 1'b1;
      tts_pkg::CD_NO_START: jump = !start;
      tts_pkg::CD_FN_NONE:  jump = stat.fn_none;
      tts_pkg::CD_N_ZERO:   jump = stat.n_zero;
      tts_pkg::CD_K_LAST:   jump = stat.k_last;
      tts_pkg::CD_DIV_MORE: jump = stat.div_more;
      default:              jump = 1'b1;
    endcase
    pc_nxt = jump ? ucw.target : pc_r + tts_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tts_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy        = (pc_r != tts_pkg::ST_IDLE);
  assign ctrl.op     = ucw.op;
  assign ctrl.accept = start && (pc_r == tts_pkg::ST_IDLE);

endmodule

/* hw/rtl/tts_dp.sv */
// Datapath: shared multiplier, radix-4 divider, term recurrence and saturating accumulator.
module tts_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tts_pkg::ctrl_t                   ctrl,
  input  logic signed [tts_pkg::X_W-1:0]   arg_x,
  input  logic [tts_pkg::FSEL_W-1:0]       fsel,
  input  logic [tts_pkg::TCNT_W-1:0]       tcnt,
  output tts_pkg::stat_t                   stat,
  output logic                             out_valid,
  output logic signed [tts_pkg::SUM_W-1:0] series_sum,
  output logic                             saturated
);

  logic                          xneg_r, xneg_nxt;
  logic [tts_pkg::AX_W-1:0]      ax_r, ax_nxt;
  logic [tts_pkg::X2_W-1:0]      x2_r, x2_nxt;
  logic [tts_pkg::K_W-1:0]       n_r, n_nxt;
  logic [tts_pkg::K_W-1:0]       k_r, k_nxt;
  logic [tts_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic                          neg_r, neg_nxt;
  logic [tts_pkg::SUM_W-1:0]     acc_r, acc_nxt;
  logic                          sat_r, sat_nxt;
  logic [tts_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [tts_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [tts_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [tts_pkg::NUM_W-1:0]     dq_r, dq_nxt;
  logic [tts_pkg::DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic                          ov_r, ov_nxt;
  logic [tts_pkg::SUM_W-1:0]     osum_r, osum_nxt;
  logic                          osat_r, osat_nxt;

  logic [tts_pkg::MAG_W-1:0]     mul_a;
  logic [tts_pkg::X2_W-1:0]      mul_b;
  logic [tts_pkg::PROD_W-1:0]    rnd;
  logic [tts_pkg::DIV_W-1:0]     dsel;
  logic [tts_pkg::DIVT_W-1:0]    t, d1, d2, d3, sub;
  logic [1:0]                    qd;
  logic                          nneg;
  logic [tts_pkg::NUM_W-1:0]     lim;
  logic signed [tts_pkg::SUM_W+1:0] acc_ext, mag_ext, s;

  always_comb begin
    if (ctrl.op == tts_pkg::OP_MUL_SQ) begin
      mul_a = tts_pkg::MAG_W'(ax_r);
      mul_b = tts_pkg::X2_W'(ax_r);
    end else begin
      mul_a = mag_r;
      mul_b = (fsel == tts_pkg::FN_EXP) ? tts_pkg::X2_W'(ax_r) : x2_r;
    end
  end

  assign rnd  = (prod_r + tts_pkg::RND_HALF) >> tts_pkg::QF;
  assign dsel = tts_pkg::divisor(fsel, k_r);

  assign d1 = tts_pkg::DIVT_W'(dvs_r);
  assign d2 = d1 << 1;
  assign d3 = d1 + d2;
  assign t  = {rem_r, dq_r[tts_pkg::NUM_W-1 -: 2]};

  always_comb begin
    priority if (t >= d3) begin
      qd = 2'd3;
      sub = d3;
    end else if (t >= d2) begin
      qd = 2'd2;
      sub = d2;
    end else if (t >= d1) begin
      qd = 2'd1;
      sub = d1;
    end else begin
      qd = 2'd0;
      sub = '0;
    end
  end

  always_comb begin
    nneg = (fsel == tts_pkg::FN_EXP) ? (neg_r ^ xneg_r) : !neg_r;
    if (dq_r == '0) begin
      nneg = 1'b0;
    end
    lim = nneg ? tts_pkg::NEG_LIMIT : tts_pkg::POS_LIMIT;
  end

  assign acc_ext = {{2{acc_r[tts_pkg::SUM_W-1]}}, acc_r};
  assign mag_ext = $signed({2'b00, mag_r});
  assign s       = neg_r ? (acc_ext - mag_ext) : (acc_ext + mag_ext);

  always_comb begin
    xneg_nxt = xneg_r;
    ax_nxt   = ax_r;
    x2_nxt   = x2_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    prod_nxt = prod_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dcnt_nxt = dcnt_r;
    ov_nxt   = 1'b0;
    osum_nxt = osum_r;
    osat_nxt = osat_r;
    unique case (ctrl.op)
      tts_pkg::OP_LOAD: begin
        if (ctrl.accept) begin
          xneg_nxt = arg_x[tts_pkg::X_W-1];
          ax_nxt   = arg_x[tts_pkg::X_W-1] ? (~arg_x + tts_pkg::X_W'(1)) : arg_x;
          n_nxt    = (tcnt > tts_pkg::TCNT_W'(tts_pkg::MAX_TERMS)) ?
                     tts_pkg::K_W'(tts_pkg::MAX_TERMS) : tts_pkg::K_W'(tcnt);
          k_nxt    = '0;
          acc_nxt  = '0;
          sat_nxt  = 1'b0;
          if (fsel == tts_pkg::FN_SIN) begin
            mag_nxt = arg_x[tts_pkg::X_W-1] ?
                      tts_pkg::MAG_W'(~arg_x + tts_pkg::X_W'(1)) :
                      tts_pkg::MAG_W'(arg_x);
            neg_nxt = arg_x[tts_pkg::X_W-1];
          end else begin
            mag_nxt = tts_pkg::Q_ONE;
            neg_nxt = 1'b0;
          end
        end
      end
      tts_pkg::OP_MUL_SQ, tts_pkg::OP_MUL_TERM: begin
        prod_nxt = tts_pkg::PROD_W'(mul_a) * tts_pkg::PROD_W'(mul_b);
      end
      tts_pkg::OP_X2: begin
        x2_nxt = rnd[tts_pkg::X2_W-1:0];
      end
      tts_pkg::OP_ACCUM: begin
        k_nxt = k_r + tts_pkg::K_W'(1);
        if (s[tts_pkg::SUM_W+1:tts_pkg::SUM_W-1] == 3'b000 ||
            s[tts_pkg::SUM_W+1:tts_pkg::SUM_W-1] == 3'b111) begin
          acc_nxt = s[tts_pkg::SUM_W-1:0];
        end else begin
          acc_nxt = s[tts_pkg::SUM_W+1] ? {1'b1, {(tts_pkg::SUM_W-1){1'b0}}} :
                                          {1'b0, {(tts_pkg::SUM_W-1){1'b1}}};
          sat_nxt = 1'b1;
        end
      end
      tts_pkg::OP_DIV_LOAD: begin
        dvs_nxt  = dsel;
        rem_nxt  = '0;
        dcnt_nxt = '0;
        dq_nxt   = rnd[tts_pkg::NUM_W-1:0] + tts_pkg::NUM_W'(dsel >> 1);
      end
      tts_pkg::OP_DIV_STEP: begin
        rem_nxt  = tts_pkg::DIV_W'(t - sub);
        dq_nxt   = {dq_r[tts_pkg::NUM_W-3:0], qd};
        dcnt_nxt = dcnt_r + tts_pkg::DCNT_W'(1);
      end
      tts_pkg::OP_NEXT: begin
        neg_nxt = nneg;
        if (dq_r > lim) begin
          mag_nxt = lim[tts_pkg::MAG_W-1:0];
          sat_nxt = 1'b1;
        end else begin
          mag_nxt = dq_r[tts_pkg::MAG_W-1:0];
        end
      end
      tts_pkg::OP_OUT_SUM: begin
        ov_nxt   = 1'b1;
        osum_nxt = acc_r;
        osat_nxt = sat_r;
      end
      tts_pkg::OP_OUT_NONE: begin
        ov_nxt   = 1'b1;
        osum_nxt = tts_pkg::Q_NEG_ONE;
        osat_nxt = 1'b0;
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xneg_r <= xneg_nxt;
    ax_r   <= ax_nxt;
    x2_r   <= x2_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    sat_r  <= sat_nxt;
    prod_r <= prod_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    dcnt_r <= dcnt_nxt;
    osum_r <= osum_nxt;
    osat_r <= osat_nxt;
  end

  assign stat.fn_none  = (fsel == tts_pkg::FN_NONE);
  assign stat.n_zero   = (n_r == '0);
  assign stat.k_last   = ((k_r + tts_pkg::K_W'(1)) == n_r);
  assign stat.div_more = (dcnt_r != tts_pkg::DCNT_W'(tts_pkg::DIV_ITER - 1));

  assign out_valid  = ov_r;
  assign series_sum = osum_r;
  assign saturated  = osat_r;

endmodule

/* hw/rtl/truncated_taylor_series_eval.sv */
// Top level of the truncated Taylor series evaluator for exp, sin and cos.
// Steps to the result strobe: for function none the squaring only; for a term count of zero
// squaring and x squared; otherwise also one pass per term of the clipped term count.
// Each further term passes through: accumulate, multiply, divider load, 19 divider steps, clip.
// One transaction at a time: start is taken again in the strobe cycle.
// Synchronous active-low reset returns the sequencer to idle and config registers to defaults.
module truncated_taylor_series_eval (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tts_pkg::X_W-1:0]       in_arg_x,
  input  logic                                 cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                 out_valid,
  output logic signed [tts_pkg::SUM_W-1:0]     out_series_sum,
  output logic                                 out_saturated
);

  logic [tts_pkg::FSEL_W-1:0] fsel_r, fsel_nxt;
  logic [tts_pkg::TCNT_W-1:0] tcnt_r, tcnt_nxt;
  tts_pkg::ctrl_t             ctrl;
  tts_pkg::stat_t             stat;

  always_comb begin
    fsel_nxt = fsel_r;
    tcnt_nxt = tcnt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tts_pkg::REG_FSEL: fsel_nxt = cfg_wdata[tts_pkg::FSEL_W-1:0];
        tts_pkg::REG_TCNT: tcnt_nxt = cfg_wdata[tts_pkg::TCNT_W-1:0];
        default:           fsel_nxt = fsel_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r <= tts_pkg::FSEL_RST;
      tcnt_r <= tts_pkg::TCNT_RST;
    end else begin
      fsel_r <= fsel_nxt;
      tcnt_r <= tcnt_nxt;
    end
  end

  tts_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  tts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .arg_x      (in_arg_x),
    .fsel       (fsel_r),
    .tcnt       (tcnt_r),
    .stat       (stat),
    .out_valid  (out_valid),
    .series_sum (out_series_sum),
    .saturated  (out_saturated)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a transaction is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

/* verif/truncated_taylor_series_eval_tb.sv */
// Self-checking testbench of the Taylor series evaluator: predicted sums versus DUT results.
module truncated_taylor_series_eval_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          GAP_PCT     = 31;
  localparam logic signed [tts_pkg::X_W-1:0] X_MAX = {1'b0, {(tts_pkg::X_W-1){1'b1}}};
  localparam logic signed [tts_pkg::X_W-1:0] X_MIN = {1'b1, {(tts_pkg::X_W-1){1'b0}}};
  localparam logic signed [tts_pkg::X_W-1:0] X_LSB = tts_pkg::X_W'(1);

  typedef struct packed {
    logic signed [tts_pkg::SUM_W-1:0] sum;
    logic                             sat;
  } series_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [tts_pkg::X_W-1:0]      in_arg_x;
  logic                                cfg_we;
  logic [tts_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [tts_pkg::CFG_DATA_W-1:0]      cfg_wdata;
  logic                                out_valid;
  logic signed [tts_pkg::SUM_W-1:0]    out_series_sum;
  logic                                out_saturated;

  logic [tts_pkg::FSEL_W-1:0] fn_sel;
  logic [tts_pkg::TCNT_W-1:0] term_cnt;
  series_t                    pending_sums[$];
  series_t                    head;
  int                         errors = 0;
  bit                         gaps_on;
  int unsigned                cycle_cnt = 0;

  truncated_taylor_series_eval u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_arg_x       (in_arg_x),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_series_sum (out_series_sum),
    .out_saturated  (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic series_t eval_series(logic [tts_pkg::FSEL_W-1:0] fsel,
                                          logic [tts_pkg::TCNT_W-1:0] tcnt,
                                          logic [tts_pkg::X_W-1:0] raw);
    logic [63:0] ax;
    logic [63:0] x2;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] d;
    logic        xneg;
    logic        neg;
    logic        sat;
    longint      acc;
    int          n;
    series_t     r;
    xneg = raw[tts_pkg::X_W-1];
    ax   = xneg ? ((64'd1 << tts_pkg::X_W) - 64'(raw)) : 64'(raw);
    x2   = (ax * ax + 64'd32768) >> tts_pkg::QF;
    if (fsel == tts_pkg::FN_NONE) begin
      r.sum = -32'sd65536;
      r.sat = 1'b0;
      return r;
    end
    n   = (tcnt > tts_pkg::MAX_TERMS) ? tts_pkg::MAX_TERMS : int'(tcnt);
    mag = (fsel == tts_pkg::FN_SIN) ? ax : 64'd65536;
    neg = (fsel == tts_pkg::FN_SIN) ? xneg : 1'b0;
    sat = 1'b0;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        case (fsel)
          tts_pkg::FN_EXP: begin
            d   = 64'(k);
            mag = (mag * ax + 64'd32768) >> tts_pkg::QF;
            neg = neg ^ xneg;
          end
          tts_pkg::FN_SIN: begin
            d   = 64'((2 * k) * (2 * k + 1));
            mag = (mag * x2 + 64'd32768) >> tts_pkg::QF;
            neg = !neg;
          end
          default: begin
            d   = 64'((2 * k - 1) * (2 * k));
            mag = (mag * x2 + 64'd32768) >> tts_pkg::QF;
            neg = !neg;
          end
        endcase
        mag = (mag + d / 2) / d;
      end
      if (mag == 0) neg = 1'b0;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) begin
        mag = lim;
        sat = 1'b1;
      end
      if (neg) acc -= longint'(mag);
      else acc += longint'(mag);
      if (acc > 64'sh7FFF_FFFF) begin
        acc = 64'sh7FFF_FFFF;
        sat = 1'b1;
      end else if (acc < -64'sh8000_0000) begin
        acc = -64'sh8000_0000;
        sat = 1'b1;
      end
    end
    r.sum = tts_pkg::SUM_W'(acc);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic signed [tts_pkg::X_W-1:0] rand_arg();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return X_MAX;
    if (pick == 1) return X_MIN;
    if (pick < 4) return tts_pkg::X_W'($urandom_range(0, 131072) - 65536);
    return tts_pkg::X_W'($urandom);
  endfunction

  function automatic logic [tts_pkg::TCNT_W-1:0] rand_terms();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 7) return tts_pkg::TCNT_W'($urandom_range(1, 6));
    if (pick < 9) return tts_pkg::TCNT_W'($urandom_range(7, tts_pkg::MAX_TERMS));
    if ($urandom_range(1) == 0) return '0;
    return tts_pkg::TCNT_W'($urandom_range(tts_pkg::MAX_TERMS + 1, 31));
  endfunction

  task automatic send_arg(logic signed [tts_pkg::X_W-1:0] x);
    if (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start    <= 1'b1;
    in_arg_x <= x;
    do @(posedge clk); while (busy);
    pending_sums.push_back(eval_series(fn_sel, term_cnt, x));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_sums.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic set_config(logic [tts_pkg::FSEL_W-1:0] fsel, logic [tts_pkg::TCNT_W-1:0] tcnt);
    cfg_we    <= 1'b1;
    cfg_index <= tts_pkg::REG_FSEL;
    cfg_wdata <= {(tts_pkg::CFG_DATA_W-tts_pkg::FSEL_W)'($urandom), fsel};
    @(posedge clk);
    cfg_index <= tts_pkg::REG_TCNT;
    cfg_wdata <= tts_pkg::CFG_DATA_W'(tcnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    fn_sel   = fsel;
    term_cnt = tcnt;
  endtask

  task automatic test_defaults();
    send_arg(X_MAX);
    send_arg('0);
    drain();
  endtask

  task automatic test_extremes();
    logic [tts_pkg::FSEL_W-1:0] fns[3];
    fns = '{tts_pkg::FN_EXP, tts_pkg::FN_SIN, tts_pkg::FN_COS};
    foreach (fns[i]) begin
      set_config(fns[i], tts_pkg::TCNT_W'(tts_pkg::MAX_TERMS));
      send_arg(X_MAX);
      send_arg(X_MIN);
      send_arg(X_LSB);
      drain();
    end
  endtask

  task automatic test_special_cases();
    set_config(tts_pkg::FN_NONE, tts_pkg::TCNT_W'(tts_pkg::MAX_TERMS));
    send_arg(rand_arg());
    drain();
    set_config(tts_pkg::FN_EXP, '0);
    send_arg(X_MAX);
    drain();
    set_config(tts_pkg::FN_COS, '1);
    send_arg(X_MIN);
    drain();
    set_config(tts_pkg::FN_SIN, tts_pkg::TCNT_W'(tts_pkg::MAX_TERMS + 1));
    send_arg('0);
    drain();
    set_config(tts_pkg::FN_EXP, tts_pkg::TCNT_W'(1));
    send_arg(X_MIN);
    drain();
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 26; p++) begin
      set_config(tts_pkg::FSEL_W'($urandom_range(3)), rand_terms());
      repeat (50) send_arg(rand_arg());
      drain();
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_config(tts_pkg::FSEL_W'($urandom_range(2)), tts_pkg::TCNT_W'($urandom_range(1, 4)));
    repeat (150) send_arg(rand_arg());
    drain();
    gaps_on = 1'b1;
  endtask

  // Each result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: series_sum %0d saturated %0b", out_series_sum,
               out_saturated);
        errors++;
      end else begin
        head = pending_sums.pop_front();
        if (out_series_sum !== head.sum) begin
          $error("series_sum mismatch: expected %0d, actual %0d", head.sum, out_series_sum);
          errors++;
        end
        if (out_saturated !== head.sat) begin
          $error("saturated mismatch: expected %0b, actual %0b", head.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_arg_x  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    fn_sel    = tts_pkg::FSEL_RST;
    term_cnt  = tts_pkg::TCNT_RST;
    gaps_on   = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_special_cases();
    test_random_mix();
    test_back_to_back();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
